FILE: sv/jfbs_pkg.sv
`default_nettype none

package jfbs_pkg;

  // Field and register widths
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 31;
  localparam int ITER_W    = 16;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 3;

  // Default grid geometry
  localparam int NODES_DEF     = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Relative tolerance 1e-3 taken as a reciprocal
  localparam int TOL_RECIP = 1000;

  // Register reset values
  localparam logic [DATA_W-1:0] COEF_SCALE_RST  = 32'd33183;
  localparam logic [DATA_W-1:0] COEF_RIGHT_RST  = 32'd57344;
  localparam logic [DATA_W-1:0] COEF_LEFT_RST   = 32'd73728;
  localparam logic [DATA_W-1:0] COEF_SOURCE_RST = 32'd1638;
  localparam logic [STEP_W-1:0] GRID_STEP_RST   = 31'd3277;
  localparam logic [DATA_W-1:0] LEFT_BND_RST    = 32'd0;
  localparam logic [DATA_W-1:0] RIGHT_BND_RST   = 32'd6553600;
  localparam logic [ITER_W-1:0] MAX_ITER_RST    = 16'd1;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_SCALE  = 3'd0,
    REG_COEF_RIGHT  = 3'd1,
    REG_COEF_LEFT   = 3'd2,
    REG_COEF_SOURCE = 3'd3,
    REG_GRID_STEP   = 3'd4,
    REG_LEFT_BND    = 3'd5,
    REG_RIGHT_BND   = 3'd6,
    REG_MAX_ITER    = 3'd7
  } cfg_reg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_LOAD1,
    ST_LOAD2,
    ST_MUL_R,
    ST_MUL_L,
    ST_MUL_S,
    ST_ACC_S,
    ST_MUL_A,
    ST_NV,
    ST_NODE,
    ST_SWEEP_END,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_RIGHT,
    MUL_LEFT,
    MUL_SOURCE,
    MUL_SCALE
  } mul_sel_t;

  // Bracket accumulator operation
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     start;
    logic     sweep_begin;
    logic     win_c;
    logic     win_r;
    logic     rd_en;
    mul_sel_t mul_sel;
    logic     mul_en;
    acc_op_t  acc_op;
    logic     nv_load;
    logic     node_done;
    logic     pos_clr;
    logic     pos_step;
    logic     sweep_end;
    logic     emit_load;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic finish;
    logic out_done;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/jfbs_ram.sv
`default_nettype none

module jfbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/jfbs_ctrl.sv
`default_nettype none

module jfbs_ctrl #(
  parameter int NODES = jfbs_pkg::NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  jfbs_pkg::dp_status_t       status,
  output jfbs_pkg::dp_cmd_t          cmd,
  output logic [$clog2(NODES)-1:0]   node_idx,
  output logic [$clog2(NODES)-1:0]   rd_idx
);

  import jfbs_pkg::*;

  localparam int IW = $clog2(NODES);

  state_t        state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic          ahead_ok;

  // look-ahead read of node i+2 only while it is still on the grid
  assign ahead_ok = ({1'b0, idx} + (IW+1)'(2)) <= (IW+1)'(NODES - 1);
  assign node_idx = idx;

  // state and node counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    idx_next   = idx;
    rd_idx     = idx;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          idx_next   = IW'(1);
          state_next = ST_LOAD0;
        end
      end
      // window fill: left boundary, node 1, node 2
      ST_LOAD0: begin
        cmd.sweep_begin = 1'b1;
        cmd.pos_clr     = 1'b1;
        cmd.rd_en       = 1'b1;
        state_next      = ST_LOAD1;
      end
      ST_LOAD1: begin
        cmd.win_c  = 1'b1;
        cmd.rd_en  = 1'b1;
        rd_idx     = IW'(2);
        state_next = ST_LOAD2;
      end
      ST_LOAD2: begin
        cmd.win_r    = 1'b1;
        cmd.pos_step = 1'b1;
        state_next   = ST_MUL_R;
      end
      // per node: four products through the shared multiplier
      ST_MUL_R: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RIGHT;
        cmd.rd_en   = ahead_ok;
        rd_idx      = idx + IW'(2);
        state_next  = ST_MUL_L;
      end
      ST_MUL_L: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LEFT;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SOURCE;
        cmd.acc_op  = ACC_ADD;
        state_next  = ST_ACC_S;
      end
      ST_ACC_S: begin
        cmd.acc_op = ACC_SUB;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SCALE;
        state_next  = ST_NV;
      end
      ST_NV: begin
        cmd.nv_load = 1'b1;
        state_next  = ST_NODE;
      end
      ST_NODE: begin
        cmd.node_done = 1'b1;
        cmd.pos_step  = 1'b1;
        if (idx == IW'(NODES - 2)) begin
          state_next = ST_SWEEP_END;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = ST_MUL_R;
        end
      end
      ST_SWEEP_END: begin
        cmd.sweep_end = 1'b1;
        if (status.finish) begin
          cmd.pos_clr = 1'b1;
          idx_next    = '0;
          state_next  = ST_EMIT_RD;
        end else begin
          idx_next   = IW'(1);
          state_next = ST_LOAD0;
        end
      end
      // result stream, one node per transfer
      ST_EMIT_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd.emit_load = 1'b1;
        state_next    = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (status.out_done) begin
          cmd.pos_step = 1'b1;
          if (idx == IW'(NODES - 1)) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/jfbs_dp.sv
`default_nettype none

module jfbs_dp #(
  parameter int NODES     = jfbs_pkg::NODES_DEF,
  parameter int FRAC_BITS = jfbs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [jfbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jfbs_pkg::DATA_W-1:0]       cfg_data,
  // controller
  input  jfbs_pkg::dp_cmd_t                 cmd,
  input  logic [$clog2(NODES)-1:0]          node_idx,
  input  logic [$clog2(NODES)-1:0]          rd_idx,
  output jfbs_pkg::dp_status_t              status,
  // input payload
  input  logic signed [jfbs_pkg::DATA_W-1:0] initial_guess,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [jfbs_pkg::IDX_W-1:0]        node_index,
  output logic signed [jfbs_pkg::DATA_W-1:0] node_position,
  output logic signed [jfbs_pkg::DATA_W-1:0] node_value,
  output logic                              converged,
  output logic [jfbs_pkg::ITER_W-1:0]       sweeps_done,
  output logic                              last_node,
  // node store
  output logic                              ram_we,
  output logic [$clog2(NODES):0]            ram_wr_addr,
  output logic [jfbs_pkg::DATA_W-1:0]       ram_wr_data,
  output logic                              ram_rd_en,
  output logic [$clog2(NODES):0]            ram_rd_addr,
  input  logic [jfbs_pkg::DATA_W-1:0]       ram_rd_data
);

  import jfbs_pkg::*;

  localparam int IW     = $clog2(NODES);
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = DATA_W + 2;
  localparam int MAG_W  = DATA_W + 1;
  localparam int TOL_W  = MAG_W + 10;

  localparam logic signed [PROD_W-1:0] RND   = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] Q_MAX = PROD_W'(32'h7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] Q_MIN = ~Q_MAX;
  localparam logic signed [ACC_W-1:0]  A_MAX = ACC_W'(32'h7FFF_FFFF);
  localparam logic signed [ACC_W-1:0]  A_MIN = ~A_MAX;

  // round half up, floor shift, saturate to 32 bits
  function automatic logic signed [DATA_W-1:0] qround(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + RND) >>> FRAC_BITS;
    if (r > Q_MAX) begin
      return DATA_W'(Q_MAX);
    end else if (r < Q_MIN) begin
      return DATA_W'(Q_MIN);
    end
    return r[DATA_W-1:0];
  endfunction

  // configuration registers
  logic signed [DATA_W-1:0] coef_scale, coef_right, coef_left, coef_source;
  logic signed [DATA_W-1:0] left_bnd, right_bnd;
  logic [STEP_W-1:0]        grid_step;
  logic [ITER_W-1:0]        max_iter;

  // solve control state
  logic [ITER_W-1:0] count;
  logic              conv;
  logic              first;
  logic              bank;

  // payload registers
  logic signed [DATA_W-1:0] guess;
  logic signed [DATA_W-1:0] xl, xc, xr;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] nv;
  logic [STEP_W-1:0]        pos;
  logic                     rd_right;

  logic signed [DATA_W-1:0] ma, mb;
  logic signed [DATA_W-1:0] q_val;
  logic signed [DATA_W-1:0] sat_acc;
  logic signed [DATA_W-1:0] win_src;
  logic signed [DATA_W-1:0] emit_val;
  logic signed [MAG_W-1:0]  diff;
  logic [MAG_W-1:0]         dmag, omag;
  logic                     tol_fail;
  logic [DATA_W-1:0]        pos_sum;
  logic [STEP_W-1:0]        pos_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_scale  <= COEF_SCALE_RST;
      coef_right  <= COEF_RIGHT_RST;
      coef_left   <= COEF_LEFT_RST;
      coef_source <= COEF_SOURCE_RST;
      grid_step   <= GRID_STEP_RST;
      left_bnd    <= LEFT_BND_RST;
      right_bnd   <= RIGHT_BND_RST;
      max_iter    <= MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_SCALE:  coef_scale  <= cfg_data;
        REG_COEF_RIGHT:  coef_right  <= cfg_data;
        REG_COEF_LEFT:   coef_left   <= cfg_data;
        REG_COEF_SOURCE: coef_source <= cfg_data;
        REG_GRID_STEP:   grid_step   <= cfg_data[STEP_W-1:0];
        REG_LEFT_BND:    left_bnd    <= cfg_data;
        REG_RIGHT_BND:   right_bnd   <= cfg_data;
        REG_MAX_ITER:    max_iter    <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_RIGHT: begin
        ma = coef_right;
        mb = xr;
      end
      MUL_LEFT: begin
        ma = coef_left;
        mb = xl;
      end
      MUL_SOURCE: begin
        ma = coef_source;
        mb = {1'b0, pos};
      end
      MUL_SCALE: begin
        ma = coef_scale;
        mb = sat_acc;
      end
      default: begin
        ma = coef_right;
        mb = xr;
      end
    endcase
  end

  assign q_val = qround(prod);

  // bracket sum saturated before the scale multiply
  always_comb begin
    if (acc > A_MAX) begin
      sat_acc = DATA_W'(A_MAX);
    end else if (acc < A_MIN) begin
      sat_acc = DATA_W'(A_MIN);
    end else begin
      sat_acc = acc[DATA_W-1:0];
    end
  end

  // tolerance test: |new-old| * 1000 > |old| fails
  assign diff     = MAG_W'(nv) - MAG_W'(xc);
  assign dmag     = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign omag     = xc[DATA_W-1] ? MAG_W'(-MAG_W'(xc)) : MAG_W'(xc);
  assign tol_fail = (TOL_W'(dmag) * TOL_W'(TOL_RECIP)) > TOL_W'(omag);

  // next window entry: right boundary, guess on the first sweep, else store
  assign win_src  = rd_right ? right_bnd : (first ? guess : ram_rd_data);
  assign emit_val = (node_idx == '0) ? left_bnd : (rd_right ? right_bnd : ram_rd_data);

  // saturating position step
  assign pos_sum = {1'b0, pos} + {1'b0, grid_step};
  assign pos_inc = pos_sum[DATA_W-1] ? '1 : pos_sum[STEP_W-1:0];

  // solve control
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      conv      <= 1'b0;
      first     <= 1'b0;
      bank      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        count <= '0;
        first <= 1'b1;
      end
      if (cmd.sweep_begin) begin
        count <= count + ITER_W'(1);
        conv  <= 1'b1;
      end else if (cmd.node_done && tol_fail) begin
        conv <= 1'b0;
      end
      if (cmd.sweep_end) begin
        bank  <= ~bank;
        first <= 1'b0;
      end
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (status.out_done) begin
        out_valid <= 1'b0;
      end
    end
  end

  // arithmetic and window registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      guess <= initial_guess;
    end
    if (cmd.rd_en) begin
      rd_right <= (rd_idx == IW'(NODES - 1));
    end
    if (cmd.mul_en) begin
      prod <= ma * mb;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc <= ACC_W'(q_val);
      ACC_ADD:  acc <= acc + ACC_W'(q_val);
      ACC_SUB:  acc <= acc - ACC_W'(q_val);
      default: ;
    endcase
    if (cmd.nv_load) begin
      nv <= q_val;
    end
    if (cmd.sweep_begin) begin
      xl <= left_bnd;
    end
    if (cmd.win_c) begin
      xc <= win_src;
    end
    if (cmd.win_r) begin
      xr <= win_src;
    end
    if (cmd.node_done) begin
      xl <= xc;
      xc <= xr;
      xr <= win_src;
    end
    if (cmd.pos_clr) begin
      pos <= '0;
    end else if (cmd.pos_step) begin
      pos <= pos_inc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      node_index    <= IDX_W'(node_idx);
      node_position <= {1'b0, pos};
      node_value    <= emit_val;
      converged     <= conv;
      sweeps_done   <= count;
      last_node     <= (node_idx == IW'(NODES - 1));
    end
  end

  // status
  assign status.finish   = conv || (count >= max_iter);
  assign status.out_done = out_valid && !out_stall;

  // node store: read the current bank, write the other
  assign ram_we      = cmd.node_done;
  assign ram_wr_addr = {~bank, node_idx};
  assign ram_wr_data = nv;
  assign ram_rd_en   = cmd.rd_en;
  assign ram_rd_addr = {bank, rd_idx};

endmodule

`default_nettype wire

FILE: sv/jacobi_fdm_boundary_solver_top.sv
`default_nettype none

// Jacobi relaxation solver for a two-point boundary-value problem on NODES
// grid points in signed fixed point with FRAC_BITS fraction bits. Each input
// transfer carries the initial guess for the interior; the end nodes take the
// left_boundary and right_boundary registers. One shared 32x32 multiplier
// forms the four products of every interior node in turn. Sweeps repeat until
// every node meets the relative tolerance of 1e-3 or max_iterations is reached
// (zero acts as one). Then NODES results stream out, node 0 first, each one
// transferred before the next is loaded, with last_node on the final one.
// A new guess is taken only once the last result has been transferred. Node
// values sit in a ping-pong RAM of 2 * 2^clog2(NODES) words that needs no
// clearing after reset. Configuration writes are meant for idle time only.
module jacobi_fdm_boundary_solver_top #(
  parameter int NODES     = jfbs_pkg::NODES_DEF,
  parameter int FRAC_BITS = jfbs_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [jfbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jfbs_pkg::DATA_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [jfbs_pkg::DATA_W-1:0] initial_guess,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [jfbs_pkg::IDX_W-1:0]         node_index,
  output logic signed [jfbs_pkg::DATA_W-1:0] node_position,
  output logic signed [jfbs_pkg::DATA_W-1:0] node_value,
  output logic                               converged,
  output logic [jfbs_pkg::ITER_W-1:0]        sweeps_done,
  output logic                               last_node
);

  import jfbs_pkg::*;

  localparam int IW        = $clog2(NODES);
  localparam int RAM_DEPTH = 2 ** (IW + 1);

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [IW-1:0]     node_idx;
  logic [IW-1:0]     rd_idx;
  logic              ram_we;
  logic [IW:0]       ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [IW:0]       ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;

  jfbs_ctrl #(
    .NODES(NODES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .node_idx (node_idx),
    .rd_idx   (rd_idx)
  );

  jfbs_dp #(
    .NODES     (NODES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .node_idx      (node_idx),
    .rd_idx        (rd_idx),
    .status        (status),
    .initial_guess (initial_guess),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .node_index    (node_index),
    .node_position (node_position),
    .node_value    (node_value),
    .converged     (converged),
    .sweeps_done   (sweeps_done),
    .last_node     (last_node),
    .ram_we        (ram_we),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_addr   (ram_rd_addr),
    .ram_rd_data   (ram_rd_data)
  );

  jfbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

FILE: sv/jfbs_checker.sv
`default_nettype none

module jfbs_assertions #(
  parameter int NODES = jfbs_pkg::NODES_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [jfbs_pkg::IDX_W-1:0]         node_index,
  input logic signed [jfbs_pkg::DATA_W-1:0] node_value,
  input logic [jfbs_pkg::ITER_W-1:0]        sweeps_done,
  input logic                               last_node
);

  import jfbs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_value) && $stable(node_index))
    else $error("result changed while stalled");

  // a new solve is busy on the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a start");

  // no new guess while results are still streaming
  a_no_input_during_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input ready while a result is pending");

  // last node flag only on the final grid index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_node |-> node_index == IDX_W'(NODES - 1))
    else $error("last_node on wrong index");

  // every solve does at least one sweep
  a_sweeps_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sweeps_done != '0)
    else $error("result reports zero sweeps");

endmodule

bind jacobi_fdm_boundary_solver_top jfbs_assertions #(.NODES(NODES)) u_checker (.*);

`default_nettype wire
